@@ design/vrp_pkg.sv @@
// Shared constants and helpers for the vertex rotate / project pipeline.
// No dependencies; imported by vertex_rotate_project_top.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

  localparam int COORD_W = 16;   // model coordinate, Q4.12
  localparam int COEF_W  = 16;   // sine / cosine, Q2.14
  localparam int ROT_W   = 24;   // rotated coordinate, Q.12 with headroom
  localparam int SUM_W   = 41;   // exact sum of two rotation products
  localparam int DEPTH_W = 19;
  localparam int PIX_W   = 6;
  localparam int IDX_W   = 3;

  localparam int DEF_COLUMNS = 60;
  localparam int DEF_ROWS    = 60;

  localparam int CAM_DEPTH = 5;
  localparam int CAM_ZOOM  = 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COS_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIN_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_COS_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIN_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_COS_Z = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIN_Z = 3'd5;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 16'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 16'sd0;

  // round Q.26 to Q.12, half up
  function automatic logic signed [ROT_W-1:0] round_q26(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s + SUM_W'(8192);
    return t[ROT_W+13:14];
  endfunction

endpackage

`default_nettype wire

@@ design/vertex_rotate_project_top.sv @@
// Vertex rotation (X, Y, Z) and perspective projection, fully pipelined.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One vertex enters per clock: busy never rises. Each accepted word comes out
// on done after passing through every stage; QB = clog2(larger canvas
// dimension) + 1 is the number of quotient bits. The vertex is rotated about
// X, then Y, then Z, the projection divide is prepared, a divide stage per
// quotient bit resolves that bit for column and row side by side, and a
// last stage places the pixel on the canvas. The receiver cannot stall, so
// results simply fall out of the pipeline. Sine and cosine registers feed
// the rotate stages directly; write them only while no vertex is in flight.
module vertex_rotate_project_top
  import vrp_pkg::*;
#(
  parameter int CANVAS_COLUMNS = DEF_COLUMNS,
  parameter int CANVAS_ROWS    = DEF_ROWS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  logic signed [COORD_W-1:0]  model_x,
  input  wire  logic signed [COORD_W-1:0]  model_y,
  input  wire  logic signed [COORD_W-1:0]  model_z,
  output logic                             done,
  output logic [PIX_W-1:0]                 pixel_x,
  output logic [PIX_W-1:0]                 pixel_y,
  output logic                             on_canvas,
  output logic signed [DEPTH_W-1:0]        depth,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  logic [IDX_W-1:0]           cfg_index,
  input  wire  logic [COEF_W-1:0]          cfg_data
);

  localparam int MAX_DIM = (CANVAS_COLUMNS > CANVAS_ROWS) ? CANVAS_COLUMNS : CANVAS_ROWS;
  localparam int QB      = $clog2(MAX_DIM) + 1;    // quotient bits
  localparam int AW      = 29;                      // dividend magnitude
  localparam int DW      = 23;                      // divisor
  localparam int RW      = AW + QB;                 // remainder / trial width
  localparam int PW      = QB + 2;                  // signed pixel width
  localparam int NW      = 30;                      // numerator x*40
  localparam int LAT     = 4 + QB + 1;
  localparam int HALF_C  = CANVAS_COLUMNS / 2;
  localparam int HALF_R  = CANVAS_ROWS / 2;

  // configuration registers
  logic signed [COEF_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x <= COEF_ONE;  sin_x <= COEF_ZERO;
      cos_y <= COEF_ONE;  sin_y <= COEF_ZERO;
      cos_z <= COEF_ONE;  sin_z <= COEF_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COS_X: cos_x <= cfg_data;
        REG_SIN_X: sin_x <= cfg_data;
        REG_COS_Y: cos_y <= cfg_data;
        REG_SIN_Y: sin_y <= cfg_data;
        REG_COS_Z: cos_z <= cfg_data;
        REG_SIN_Z: sin_z <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------- rotate X
  logic signed [ROT_W-1:0] in_x, in_y, in_z;
  assign in_x = ROT_W'(model_x);
  assign in_y = ROT_W'(model_y);
  assign in_z = ROT_W'(model_z);

  logic signed [SUM_W-1:0] sx_y, sx_z;
  assign sx_y = in_y * cos_x - in_z * sin_x;
  assign sx_z = in_y * sin_x + in_z * cos_x;

  logic                    v1;
  logic signed [ROT_W-1:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    x1 <= in_x;
    y1 <= round_q26(sx_y);
    z1 <= round_q26(sx_z);
  end

  // ---------------------------------------------------------------- rotate Y
  logic signed [SUM_W-1:0] sy_x, sy_z;
  assign sy_x = x1 * cos_y + z1 * sin_y;
  assign sy_z = z1 * cos_y - x1 * sin_y;

  logic                    v2;
  logic signed [ROT_W-1:0] x2, y2, z2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    x2 <= round_q26(sy_x);
    y2 <= y1;
    z2 <= round_q26(sy_z);
  end

  // ---------------------------------------------------------------- rotate Z
  logic signed [SUM_W-1:0] sz_x, sz_y;
  assign sz_x = x2 * cos_z - y2 * sin_z;
  assign sz_y = x2 * sin_z + y2 * cos_z;

  logic                    v3;
  logic signed [ROT_W-1:0] x3, y3, z3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    x3 <= round_q26(sz_x);
    y3 <= round_q26(sz_y);
    z3 <= z2;
  end

  // ------------------------------------------------------ projection setup
  // Floor division of n by den (den > 0) is done on magnitudes: a negative
  // n uses |n| + den - 1 so the unsigned quotient is the ceiling, negated
  // later. Quotients of QB bits or more can never land on the canvas.
  logic signed [ROT_W-1:0] den_s;
  logic signed [NW-1:0]    num_x, num_y, den_w;
  logic signed [NW-1:0]    mag_x, mag_y;
  logic [RW-1:0]           lim;
  logic signed [DEPTH_W-1:0] depth_sat;

  assign den_s = z3 + ROT_W'(CAM_DEPTH * 4096);
  assign den_w = NW'(den_s);
  assign num_x = NW'(x3) * NW'(CAM_DEPTH * CAM_ZOOM);
  assign num_y = NW'(y3) * NW'(CAM_DEPTH * CAM_ZOOM);
  assign mag_x = num_x[NW-1] ? (-num_x + den_w - NW'(1)) : num_x;
  assign mag_y = num_y[NW-1] ? (-num_y + den_w - NW'(1)) : num_y;
  assign lim   = RW'(den_s[DW-1:0]) << QB;

  always_comb begin
    if (z3 > ROT_W'(32767))        depth_sat = {1'b0, {(DEPTH_W-1){1'b1}}};
    else if (z3 < -ROT_W'(32768))  depth_sat = {1'b1, {(DEPTH_W-1){1'b0}}};
    else                           depth_sat = {z3[15:0], 3'b000};
  end

  logic                      v4, ok4, neg_x4, neg_y4, ovf_x4, ovf_y4;
  logic [DW-1:0]             den4;
  logic [AW-1:0]             rem_x4, rem_y4;
  logic signed [DEPTH_W-1:0] depth4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    ok4    <= den_s > 0;
    den4   <= den_s[DW-1:0];
    neg_x4 <= num_x[NW-1];
    neg_y4 <= num_y[NW-1];
    rem_x4 <= mag_x[AW-1:0];
    rem_y4 <= mag_y[AW-1:0];
    ovf_x4 <= RW'(mag_x[AW-1:0]) >= lim;
    ovf_y4 <= RW'(mag_y[AW-1:0]) >= lim;
    depth4 <= depth_sat;
  end

  // ------------------------------------------------------ divide, one bit a stage
  logic                      dv    [0:QB];
  logic                      dok   [0:QB];
  logic                      dnx   [0:QB];
  logic                      dny   [0:QB];
  logic                      dox   [0:QB];
  logic                      doy   [0:QB];
  logic [DW-1:0]             dden  [0:QB];
  logic [RW-1:0]             drx   [0:QB];
  logic [RW-1:0]             dry   [0:QB];
  logic [QB-1:0]             dqx   [0:QB];
  logic [QB-1:0]             dqy   [0:QB];
  logic signed [DEPTH_W-1:0] ddep  [0:QB];

  assign dv[0]   = v4;
  assign dok[0]  = ok4;
  assign dnx[0]  = neg_x4;
  assign dny[0]  = neg_y4;
  assign dox[0]  = ovf_x4;
  assign doy[0]  = ovf_y4;
  assign dden[0] = den4;
  assign drx[0]  = RW'(rem_x4);
  assign dry[0]  = RW'(rem_y4);
  assign dqx[0]  = '0;
  assign dqy[0]  = '0;
  assign ddep[0] = depth4;

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_div
      logic [RW-1:0] trial;
      logic          take_x, take_y;
      assign trial  = RW'(dden[k]) << (QB - 1 - k);
      assign take_x = drx[k] >= trial;
      assign take_y = dry[k] >= trial;

      always_ff @(posedge clk) begin
        if (rst) dv[k+1] <= 1'b0;
        else     dv[k+1] <= dv[k];
        dok[k+1]  <= dok[k];
        dnx[k+1]  <= dnx[k];
        dny[k+1]  <= dny[k];
        dox[k+1]  <= dox[k];
        doy[k+1]  <= doy[k];
        dden[k+1] <= dden[k];
        ddep[k+1] <= ddep[k];
        drx[k+1]  <= take_x ? drx[k] - trial : drx[k];
        dry[k+1]  <= take_y ? dry[k] - trial : dry[k];
        dqx[k+1]  <= {dqx[k][QB-2:0], take_x};
        dqy[k+1]  <= {dqy[k][QB-2:0], take_y};
      end
    end
  endgenerate

  // ------------------------------------------------------ place on canvas
  logic signed [PW-1:0] qx, qy, px, py;
  logic                 on_next;

  assign qx = dnx[QB] ? -PW'(dqx[QB]) : PW'(dqx[QB]);
  assign qy = dny[QB] ? -PW'(dqy[QB]) : PW'(dqy[QB]);
  assign px = qx + PW'(HALF_C);
  assign py = qy + PW'(HALF_R);
  assign on_next = dok[QB] && !dox[QB] && !doy[QB]
                && px >= 0 && px < PW'(CANVAS_COLUMNS)
                && py >= 0 && py < PW'(CANVAS_ROWS);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[QB];
    on_canvas <= on_next;
    pixel_x   <= on_next ? px[PIX_W-1:0] : '0;
    pixel_y   <= on_next ? py[PIX_W-1:0] : '0;
    depth     <= ddep[QB];
  end

  // ------------------------------------------------------ checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching accepted word");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !on_canvas) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("off-canvas result carries a nonzero pixel");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("pipeline refused a word");

endmodule

`default_nettype wire

@@ sim/vertex_rotate_project_checker.sv @@
// Checker for vertex_rotate_project_top: watches the vertex, result and
// register channels, predicts each result and compares it. Depends on vrp_pkg.
`timescale 1ns / 1ps

module vertex_rotate_project_checker
  import vrp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic signed [COORD_W-1:0]  model_x,
  input  logic signed [COORD_W-1:0]  model_y,
  input  logic signed [COORD_W-1:0]  model_z,
  input  logic                       done,
  input  logic [PIX_W-1:0]           pixel_x,
  input  logic [PIX_W-1:0]           pixel_y,
  input  logic                       on_canvas,
  input  logic signed [DEPTH_W-1:0]  depth,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]          cfg_data,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic [PIX_W-1:0]          px;
    logic [PIX_W-1:0]          py;
    logic                      on;
    logic signed [DEPTH_W-1:0] dep;
  } pixel_word_t;

  pixel_word_t projected_q[$];
  logic signed [COEF_W-1:0] cx, sx, cy, sy, cz, sz;

  // Q.26 to Q.12, round half up
  function automatic longint to_q12(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic pixel_word_t project_vertex(input longint x0, input longint y0,
                                                 input longint z0);
    longint y1, z1, x2, z2, x3, y3, dep, den, px, py;
    logic on;
    pixel_word_t w;
    y1 = to_q12(y0 * cx - z0 * sx);
    z1 = to_q12(y0 * sx + z0 * cx);
    x2 = to_q12(x0 * cy + z1 * sy);
    z2 = to_q12(z1 * cy - x0 * sy);
    x3 = to_q12(x2 * cz - y1 * sz);
    y3 = to_q12(x2 * sz + y1 * cz);
    dep = z2 * CAM_ZOOM;
    if (dep > 262143) dep = 262143;
    if (dep < -262144) dep = -262144;
    on = 1'b0;
    px = 0;
    py = 0;
    den = z2 + CAM_DEPTH * 4096;
    // on or behind the camera plane: no division, never on canvas
    if (den > 0) begin
      px = floor_quot(x3 * (CAM_DEPTH * CAM_ZOOM), den) + DEF_COLUMNS / 2;
      py = floor_quot(y3 * (CAM_DEPTH * CAM_ZOOM), den) + DEF_ROWS / 2;
      on = (px >= 0 && px < DEF_COLUMNS && py >= 0 && py < DEF_ROWS);
    end
    if (!on) begin
      px = 0;
      py = 0;
    end
    w.px = px[PIX_W-1:0];
    w.py = py[PIX_W-1:0];
    w.on = on;
    w.dep = dep[DEPTH_W-1:0];
    return w;
  endfunction

  assign pending = projected_q.size();

  always @(posedge clk) begin
    pixel_word_t exp_w;
    if (rst) begin
      cx <= COEF_ONE; sx <= COEF_ZERO;
      cy <= COEF_ONE; sy <= COEF_ZERO;
      cz <= COEF_ONE; sz <= COEF_ZERO;
      projected_q.delete();
      errors = 0;
    end else begin
      if (start && !busy)
        projected_q = {projected_q, project_vertex(model_x, model_y, model_z)};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COS_X: cx <= $signed(cfg_data);
          REG_SIN_X: sx <= $signed(cfg_data);
          REG_COS_Y: cy <= $signed(cfg_data);
          REG_SIN_Y: sy <= $signed(cfg_data);
          REG_COS_Z: cz <= $signed(cfg_data);
          REG_SIN_Z: sz <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (done) begin
        if (projected_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_w = projected_q.pop_front();
          if (exp_w !== {pixel_x, pixel_y, on_canvas, depth}) begin
            errors = errors + 1;
            if (errors <= 10)
              $display({"mismatch: exp px=%0d py=%0d on=%0d depth=%0d, ",
                        "got px=%0d py=%0d on=%0d depth=%0d"},
                       exp_w.px, exp_w.py, exp_w.on, exp_w.dep,
                       pixel_x, pixel_y, on_canvas, depth);
          end
        end
      end
    end
  end

endmodule

@@ sim/vertex_rotate_project_top_test.sv @@
// Testbench top for vertex_rotate_project_top: drives vertex words and
// register writes, and gives the verdict. Depends on vrp_pkg and the checker.
`timescale 1ns / 1ps

module vertex_rotate_project_top_test;
  import vrp_pkg::*;

  localparam int DRAIN_CYCLES = 40;    // well past the depth of the pipeline
  localparam int STALL_LIMIT  = 5000;  // cycles with no handshake of any kind

  logic clk, rst, start, busy, done, on_canvas, cfg_valid, cfg_ready;
  logic signed [COORD_W-1:0] model_x, model_y, model_z;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic signed [DEPTH_W-1:0] depth;
  logic [IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;
  int errors, pending, quiet_cycles;

  vertex_rotate_project_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .model_x(model_x), .model_y(model_y), .model_z(model_z),
    .done(done), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .on_canvas(on_canvas), .depth(depth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vertex_rotate_project_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .model_x(model_x), .model_y(model_y), .model_z(model_z),
    .done(done), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .on_canvas(on_canvas), .depth(depth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one vertex word and hold it until accepted. Start stays high on
  // return so back-to-back words stream one per cycle.
  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    start <= 1'b1;
    model_x <= x;
    model_y <= y;
    model_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a stretch of idle cycles.
  task automatic idle_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every predicted word is out, then let the pipeline settle
  // so no register changes under a vertex in flight.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six coefficients back to back, plus writes to the two unused
  // indexes that must be ignored. Valid stays high across the burst.
  task automatic load_coefs(input logic [15:0] c_x, input logic [15:0] s_x,
                            input logic [15:0] c_y, input logic [15:0] s_y,
                            input logic [15:0] c_z, input logic [15:0] s_z);
    logic [15:0] vals [8];
    vals[0] = c_x; vals[1] = s_x; vals[2] = c_y;
    vals[3] = s_y; vals[4] = c_z; vals[5] = s_z;
    vals[6] = 16'($urandom);
    vals[7] = 16'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coef();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // Mostly small vertices that land on the canvas; the rest is full-range
  // noise, vertices near the camera plane and hard bit patterns.
  task automatic send_random_vertex();
    int mode;
    logic [15:0] x, y, z;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      x = 16'($urandom_range(0, 12000) - 6000);
      y = 16'($urandom_range(0, 12000) - 6000);
      z = 16'($urandom_range(0, 12000) - 6000);
    end else if (mode < 85) begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    end else if (mode < 95) begin
      x = 16'($urandom_range(0, 8000) - 4000);
      y = 16'($urandom_range(0, 8000) - 4000);
      z = 16'($urandom_range(0, 400) - 20680);
    end else begin
      x = $urandom_range(0, 1) ? 16'hAAAA : 16'h5555;
      y = $urandom_range(0, 1) ? 16'hFFFF : 16'h8000;
      z = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
    end
    send_vertex(x, y, z);
  endtask

  // Bursts of random length, random gaps, and a full drain now and then.
  task automatic random_phase(input int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_random_vertex();
        sent++;
      end
      if ($urandom_range(0, 19) == 0) drain_pipeline();
      else if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 20));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    model_x = '0;
    model_y = '0;
    model_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under reset coefficients (no rotation).
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7FFF, 16'h8000, 16'h0000);
    send_vertex(16'd4096, 16'd4096, 16'd0);
    send_vertex(-16'sd4096, -16'sd4096, 16'd0);
    // on the camera plane, just in front, just behind
    send_vertex(16'd100, 16'd100, -16'sd20480);
    send_vertex(16'd1, 16'd1, -16'sd20479);
    send_vertex(16'd1, 16'd1, -16'sd20481);
    // canvas edges: pixel 59 fits, 60 falls off; negative side too
    send_vertex(16'd15020, 16'd0, 16'd0);
    send_vertex(16'd15360, 16'd0, 16'd0);
    send_vertex(-16'sd15360, 16'd0, 16'd0);
    send_vertex(-16'sd15361, 16'd0, 16'd0);
    send_vertex(16'd0, 16'd15360, 16'd0);
    send_vertex(16'd0, -16'sd15361, 16'd0);
    // deep and far: depth range extremes both ways, just short of saturation
    send_vertex(16'd0, 16'd0, 16'h7FFF);
    send_vertex(16'd0, 16'd0, 16'h8000);
    drain_pipeline();

    // Sines at the extremes: every rotate stage swaps axes.
    load_coefs(16'd0, 16'd16384, 16'd0, -16'sd16384, 16'd0, 16'd16384);
    send_vertex(16'd4096, 16'd2048, 16'd1024);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(16'h8000, 16'h7FFF, 16'h8000);
    random_phase(200);
    drain_pipeline();

    // Negative unit cosines.
    load_coefs(-16'sd16384, 16'd0, -16'sd16384, 16'd0, -16'sd16384, 16'd0);
    random_phase(200);
    drain_pipeline();

    // Beyond +-1.0: full Q2.14 range, intermediates grow widest here.
    load_coefs(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    random_phase(150);
    drain_pipeline();

    // Random rotations.
    for (int p = 0; p < 4; p++) begin
      load_coefs(rand_coef(), rand_coef(), rand_coef(),
                 rand_coef(), rand_coef(), rand_coef());
      random_phase(180);
      drain_pipeline();
    end

    // Back to identity for the tail.
    load_coefs(16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0);
    random_phase(70);
    drain_pipeline();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
